FILE: hw/rtl/tpsr_pkg.sv
// shared types, widths and codes of the triple product rounding unit
package tpsr_pkg;

  localparam int SIG_W  = 53;
  localparam int EXP_W  = 14;
  localparam int PROD_W = 159;
  localparam int SHIFT_W = 8;

  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_DOMAIN   = 2'd3;

  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;

  typedef logic signed [EXP_W-1:0] exp_t;
  typedef logic [SIG_W-1:0]        sig_t;
  typedef logic [PROD_W-1:0]       prod_t;

  typedef struct packed {
    logic bad;
    logic zero;
  } flag_t;

endpackage

FILE: hw/rtl/tpsr_if.sv
// valid/ready channels for operand triples and rounded results
interface tpsr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] factor_a;
  logic [63:0] factor_b;
  logic [63:0] factor_c;
  modport source (output valid, output factor_a, output factor_b, output factor_c,
                  input ready);
  modport sink   (input valid, input factor_a, input factor_b, input factor_c,
                  output ready);
endinterface

interface tpsr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] product_bits;
  logic [1:0]  status;
  modport source (output valid, output product_bits, output status, input ready);
  modport sink   (input valid, input product_bits, input status, output ready);
endinterface

FILE: hw/rtl/tpsr_unpack.sv
// operand classification and significand normalization, two stages
module tpsr_unpack import tpsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        v_in,
  input  logic [63:0] fa,
  input  logic [63:0] fb,
  input  logic [63:0] fc,
  output logic        v_out,
  output sig_t        sig_a,
  output sig_t        sig_b,
  output sig_t        sig_c,
  output exp_t        pexp,
  output flag_t       flags
);

  function automatic logic [5:0] lzc(input logic [51:0] m);
    logic [5:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  logic [63:0] fv [3];
  assign fv[0] = fa;
  assign fv[1] = fb;
  assign fv[2] = fc;

  // stage 1: fields, leading zero count, domain and zero flags
  logic        v1;
  logic [51:0] m1 [3];
  logic [10:0] e1 [3];
  logic [5:0]  s1 [3];
  flag_t       f1;
  flag_t       f1_next;

  always_comb begin
    f1_next = '0;
    for (int i = 0; i < 3; i++) begin
      if (fv[i][62:0] == 63'd0) f1_next.zero = 1'b1;
      else if (fv[i][63] || fv[i][62:52] == 11'h7FF) f1_next.bad = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v_in;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i] <= fv[i][51:0];
        e1[i] <= fv[i][62:52];
        s1[i] <= lzc(fv[i][51:0]) + 6'd1;
      end
      f1 <= f1_next;
    end
  end

  // stage 2: normalize subnormals and sum the exponents
  sig_t sig_next [3];
  exp_t ex_next  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (e1[i] != 11'd0) begin
        sig_next[i] = {1'b1, m1[i]};
        ex_next[i]  = exp_t'({3'b000, e1[i]}) - exp_t'(1075);
      end else begin
        sig_next[i] = {1'b0, m1[i]} << s1[i];
        ex_next[i]  = exp_t'(-1074) - exp_t'({8'b0, s1[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v1;
    end
    if (en) begin
      sig_a <= sig_next[0];
      sig_b <= sig_next[1];
      sig_c <= sig_next[2];
      pexp  <= ex_next[0] + ex_next[1] + ex_next[2];
      flags <= f1;
    end
  end

endmodule

FILE: hw/rtl/tpsr_mult.sv
// exact 159-bit product from 32-bit partial products, five stages
module tpsr_mult import tpsr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  v_in,
  input  sig_t  sig_a,
  input  sig_t  sig_b,
  input  sig_t  sig_c,
  input  exp_t  pexp_in,
  input  flag_t flags_in,
  output logic  v_out,
  output prod_t full,
  output exp_t  pexp_out,
  output flag_t flags_out
);

  logic  v1, v2, v3, v4;
  exp_t  x1, x2, x3, x4;
  flag_t g1, g2, g3, g4;
  sig_t  c1, c2;

  // stage 1: a times b partial products
  logic [63:0] pp00;
  logic [52:0] pp01, pp10;
  logic [41:0] pp11;
  // stage 2: a times b
  logic [105:0] ab;
  // stage 3: ab times c partial products
  logic [63:0] q0 [3];
  logic [41:0] q3;
  logic [52:0] r0 [3];
  logic [30:0] r3;
  // stage 4: two column sums
  logic [137:0] s0;
  logic [126:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v_out <= 1'b0;
    end else if (en) begin
      v1 <= v_in; v2 <= v1; v3 <= v2; v4 <= v3; v_out <= v4;
    end
    if (en) begin
      pp00 <= sig_a[31:0] * sig_b[31:0];
      pp01 <= sig_a[31:0] * sig_b[52:32];
      pp10 <= sig_a[52:32] * sig_b[31:0];
      pp11 <= sig_a[52:32] * sig_b[52:32];
      c1 <= sig_c; x1 <= pexp_in; g1 <= flags_in;

      ab <= 106'(pp00) + (106'(pp01) << 32) + (106'(pp10) << 32) + (106'(pp11) << 64);
      c2 <= c1; x2 <= x1; g2 <= g1;

      for (int k = 0; k < 3; k++) begin
        q0[k] <= ab[32*k +: 32] * c2[31:0];
        r0[k] <= ab[32*k +: 32] * c2[52:32];
      end
      q3 <= ab[105:96] * c2[31:0];
      r3 <= ab[105:96] * c2[52:32];
      x3 <= x2; g3 <= g2;

      s0 <= 138'(q0[0]) + (138'(q0[1]) << 32) + (138'(q0[2]) << 64) + (138'(q3) << 96);
      s1 <= 127'(r0[0]) + (127'(r0[1]) << 32) + (127'(r0[2]) << 64) + (127'(r3) << 96);
      x4 <= x3; g4 <= g3;

      full      <= PROD_W'(s0) + (PROD_W'(s1) << 32);
      pexp_out  <= x4;
      flags_out <= g4;
    end
  end

endmodule

FILE: hw/rtl/tpsr_round.sv
// exponent range, sticky shift, nearest-even rounding and packing, three stages
module tpsr_round import tpsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        v_in,
  input  prod_t       full,
  input  exp_t        pexp,
  input  flag_t       flags,
  output logic        v_out,
  output logic [63:0] product_bits,
  output logic [1:0]  status
);

  // stage 1: leading bit position, range checks, shift amount
  logic               v1;
  prod_t              p1;
  exp_t               lead1;
  logic               ovf1, norm1;
  logic [SHIFT_W-1:0] sh1;
  flag_t              f1;
  exp_t               top_idx, lead_next, sub_sh;
  logic [SHIFT_W-1:0] sh_next;

  always_comb begin
    priority if (full[158]) top_idx = exp_t'(158);
    else if (full[157])     top_idx = exp_t'(157);
    else                    top_idx = exp_t'(156);
    lead_next = pexp + top_idx;
    sub_sh    = exp_t'(-1074) - pexp;
    if (lead_next >= exp_t'(-1022)) begin
      sh_next = SHIFT_W'(top_idx - exp_t'(52));
    end else if (sub_sh > exp_t'(160)) begin
      sh_next = SHIFT_W'(160);
    end else begin
      sh_next = SHIFT_W'(sub_sh);
    end
  end

  // stage 2: aligned significand, round and sticky bits
  logic        v2;
  logic [53:0] r2;
  logic        rnd2, stk2;
  exp_t        lead2;
  logic        ovf2, norm2;
  flag_t       f2;
  prod_t       t_next, mask_next;
  logic [SHIFT_W-1:0] shm1;

  always_comb begin
    shm1      = sh1 - SHIFT_W'(1);
    t_next    = p1 >> shm1;
    mask_next = ~({PROD_W{1'b1}} << shm1);
  end

  // stage 3: increment and result selection
  logic [53:0] rr;
  logic [10:0] expf;
  logic [63:0] bits_next;
  logic [1:0]  st_next;

  always_comb begin
    rr   = r2 + 54'(rnd2 && (stk2 || r2[0]));
    expf = 11'(lead2 + exp_t'(1023)) + 11'(rr[53]);
    priority if (f2.bad) begin
      bits_next = '0; st_next = ST_DOMAIN;
    end else if (f2.zero) begin
      bits_next = '0; st_next = ST_ZERO;
    end else if (ovf2) begin
      bits_next = POS_INF; st_next = ST_OVERFLOW;
    end else if (rr == 54'd0) begin
      bits_next = '0; st_next = ST_ZERO;
    end else if (lead2 == exp_t'(1023) && rr[53]) begin
      bits_next = POS_INF; st_next = ST_OVERFLOW;
    end else if (norm2) begin
      bits_next = {1'b0, expf, rr[53] ? 52'd0 : rr[51:0]};
      st_next   = ST_NORMAL;
    end else begin
      bits_next = {10'd0, rr};
      st_next   = ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v_out <= 1'b0;
    end else if (en) begin
      v1 <= v_in; v2 <= v1; v_out <= v2;
    end
    if (en) begin
      p1    <= full;
      lead1 <= lead_next;
      ovf1  <= lead_next > exp_t'(1023);
      norm1 <= lead_next >= exp_t'(-1022);
      sh1   <= sh_next;
      f1    <= flags;

      r2    <= t_next[54:1];
      rnd2  <= t_next[0];
      stk2  <= |(p1 & mask_next);
      lead2 <= lead1;
      ovf2  <= ovf1;
      norm2 <= norm1;
      f2    <= f1;

      product_bits <= bits_next;
      status       <= st_next;
    end
  end

endmodule

FILE: hw/rtl/triple_product_single_rounding_unit.sv
// top level of the triple product unit with one rounding step
//
//  channel  dir  payload                       handshake
//  in_ch    in   factor_a, factor_b, factor_c  valid / ready
//  out_ch   out  product_bits, status          valid / ready
//
// one operand triple per cycle while no result is held at the output;
// each passes the unpack stages, two multiply levels, shift and round stages
// rst clears the stage valid bits; data registers are not reset
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
module triple_product_single_rounding_unit import tpsr_pkg::*; (
  input logic        clk,
  input logic        rst,
  tpsr_in_if.sink    in_ch,
  tpsr_out_if.source out_ch
);

  logic  en;
  logic  v_u, v_m;
  sig_t  sa, sb, sc;
  exp_t  pexp_u, pexp_m;
  flag_t fl_u, fl_m;
  prod_t full;

  // pipeline advances unless the result register is held
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  tpsr_unpack u_unpack (
    .clk, .rst, .en,
    .v_in (in_ch.valid),
    .fa (in_ch.factor_a), .fb (in_ch.factor_b), .fc (in_ch.factor_c),
    .v_out (v_u), .sig_a (sa), .sig_b (sb), .sig_c (sc),
    .pexp (pexp_u), .flags (fl_u)
  );

  tpsr_mult u_mult (
    .clk, .rst, .en,
    .v_in (v_u), .sig_a (sa), .sig_b (sb), .sig_c (sc),
    .pexp_in (pexp_u), .flags_in (fl_u),
    .v_out (v_m), .full (full), .pexp_out (pexp_m), .flags_out (fl_m)
  );

  tpsr_round u_round (
    .clk, .rst, .en,
    .v_in (v_m), .full (full), .pexp (pexp_m), .flags (fl_m),
    .v_out (out_ch.valid),
    .product_bits (out_ch.product_bits),
    .status (out_ch.status)
  );

  // no item enters while a result is held
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> (!out_ch.valid || out_ch.ready))
    else $error("item accepted during stall");

  // domain and zero results carry +0
  a_zero_bits: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == ST_DOMAIN || out_ch.status == ST_ZERO))
    |-> (out_ch.product_bits == 64'd0))
    else $error("zero status with nonzero bits");

  // overflow gives +infinity
  a_ovf_bits: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_OVERFLOW) |-> (out_ch.product_bits == POS_INF))
    else $error("overflow without infinity");

  // finite results are positive, nonzero and not infinite
  a_normal_bits: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_NORMAL)
    |-> (!out_ch.product_bits[63] && out_ch.product_bits[62:52] != 11'h7FF
         && out_ch.product_bits != 64'd0))
    else $error("bad finite result");

endmodule
